/* rtl/hrp_pkg.sv */
// ============================================================================
// HTTP request head parser package
// Shared types, codes and fixed strings for the request head parser.
// ============================================================================
package hrp_pkg;

   localparam int unsigned TOKEN_LEN_W     = 14;
   localparam int unsigned TOTAL_W         = 17;
   localparam int unsigned MAX_METHOD_LEN  = 8;
   localparam int unsigned MAX_VERSION_LEN = 8;
   localparam int unsigned SHORT_DEPTH     = 8;
   localparam int unsigned METHOD_COUNT    = 9;

   localparam logic [1:0] CMD_DATA     = 2'd0;
   localparam logic [1:0] CMD_CLOSE    = 2'd1;
   localparam logic [1:0] CMD_START    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [2:0] ST_PROGRESS = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_BAD      = 3'd2;
   localparam logic [2:0] ST_CLOSED   = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_METHOD  = 3'd1;
   localparam logic [2:0] KIND_URI     = 3'd2;
   localparam logic [2:0] KIND_VERSION = 3'd3;
   localparam logic [2:0] KIND_KEY     = 3'd4;
   localparam logic [2:0] KIND_VALUE   = 3'd5;

   localparam logic [1:0] CSR_URI_MAX   = 2'd0;
   localparam logic [1:0] CSR_KEY_MAX   = 2'd1;
   localparam logic [1:0] CSR_VALUE_MAX = 2'd2;
   localparam logic [1:0] CSR_TOTAL_MAX = 2'd3;

   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   localparam logic [7:0] METHOD_CHARS [0:8][0:7] = '{
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] METHOD_LEN [0:8] = '{
      4'd7, 4'd6, 4'd3, 4'd4, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5
   };
   localparam logic [7:0] VERSION_CHARS [0:7] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
   localparam logic [3:0] VERSION_CHAR_COUNT = 4'd8;

   typedef enum logic [13:0] {
      PH_METHOD    = 14'h0001,
      PH_URI       = 14'h0002,
      PH_VERSION   = 14'h0004,
      PH_RL_LF     = 14'h0008,
      PH_H_START   = 14'h0010,
      PH_H_KEY     = 14'h0020,
      PH_H_SPLIT1  = 14'h0040,
      PH_H_SPLIT2  = 14'h0080,
      PH_H_VALUE   = 14'h0100,
      PH_H_LF      = 14'h0200,
      PH_BLANK_LF  = 14'h0400,
      PH_DONE      = 14'h0800,
      PH_BAD       = 14'h1000,
      PH_CLOSED    = 14'h2000
   } phase_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] token_kind;
      logic [7:0] token_byte;
      logic       token_end;
      logic [3:0] method_code;
   } result_type;

   typedef struct packed {
      logic       en;
      logic [2:0] index;
      logic [7:0] data;
   } store_write_type;

   typedef struct packed {
      logic [METHOD_COUNT-1:0] method_hit;
      logic                    version_hit;
   } match_type;

   typedef struct packed {
      logic [13:0] uri_max;
      logic [7:0]  key_max;
      logic [13:0] value_max;
      logic [15:0] total_max;
   } limits_type;

endpackage

/* rtl/hrp_char_store.sv */
// ============================================================================
// Short token store
// Holds the first bytes of the method or version and compares them against
// the fixed method names and the protocol version.
// ============================================================================
module hrp_char_store (
   input  logic                     clock,
   input  hrp_pkg::store_write_type wr,
   output hrp_pkg::match_type       match
);

   logic [7:0] chars_ff [hrp_pkg::SHORT_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         chars_ff[wr.index] <= wr.data;
      end
   end

   always_comb begin
      match = '0;
      for (int m = 0; m < hrp_pkg::METHOD_COUNT; m++) begin
         match.method_hit[m] = 1'b1;
         for (int j = 0; j < hrp_pkg::SHORT_DEPTH; j++) begin
            if (4'(j) < hrp_pkg::METHOD_LEN[m] &&
                chars_ff[j] != hrp_pkg::METHOD_CHARS[m][j]) begin
               match.method_hit[m] = 1'b0;
            end
         end
      end
      match.version_hit = 1'b1;
      for (int j = 0; j < hrp_pkg::SHORT_DEPTH; j++) begin
         if (chars_ff[j] != hrp_pkg::VERSION_CHARS[j]) begin
            match.version_hit = 1'b0;
         end
      end
   end

endmodule

/* rtl/hrp_parse_core.sv */
// ============================================================================
// Request head parse core
// Per-item phase machine, token length and header total tracking, and the
// result for each item.
// ============================================================================
module hrp_parse_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [1:0]               command,
   input  logic [7:0]               data_byte,
   input  hrp_pkg::limits_type      limits,
   input  hrp_pkg::match_type       match,
   output hrp_pkg::store_write_type wr,
   output hrp_pkg::result_type      result
);

   hrp_pkg::phase_type                  phase_ff, phase_in;
   logic [hrp_pkg::TOKEN_LEN_W-1:0]     tlen_ff, tlen_in;
   logic [hrp_pkg::TOTAL_W-1:0]         total_ff, total_in;
   logic [hrp_pkg::TOTAL_W-1:0]         total_sum;
   logic                                bad;
   logic                                finished;
   logic                                method_ok;
   logic [3:0]                          method_code;
   logic                                version_ok;
   logic                                is_upper, is_lower, is_print, is_key;
   logic                                short_room;

   assign is_upper   = data_byte >= 8'h41 && data_byte <= 8'h5A;
   assign is_lower   = data_byte >= 8'h61 && data_byte <= 8'h7A;
   assign is_print   = data_byte >= 8'h20 && data_byte <= 8'h7E;
   assign is_key     = is_upper || is_lower || data_byte == hrp_pkg::CHAR_DASH;
   assign short_room = tlen_ff < hrp_pkg::TOKEN_LEN_W'(hrp_pkg::SHORT_DEPTH);
   assign finished   = phase_ff == hrp_pkg::PH_DONE || phase_ff == hrp_pkg::PH_BAD ||
                       phase_ff == hrp_pkg::PH_CLOSED;
   assign total_sum  = total_ff + {{(hrp_pkg::TOTAL_W-hrp_pkg::TOKEN_LEN_W){1'b0}}, tlen_ff};
   assign version_ok = match.version_hit &&
                       tlen_ff == hrp_pkg::TOKEN_LEN_W'(hrp_pkg::VERSION_CHAR_COUNT);

   always_comb begin
      method_ok   = 1'b0;
      method_code = 4'd0;
      for (int m = hrp_pkg::METHOD_COUNT - 1; m >= 0; m--) begin
         if (match.method_hit[m] &&
             tlen_ff == hrp_pkg::TOKEN_LEN_W'(hrp_pkg::METHOD_LEN[m])) begin
            method_ok   = 1'b1;
            method_code = 4'(m);
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      tlen_in    = tlen_ff;
      total_in   = total_ff;
      bad        = 1'b0;
      wr.en      = 1'b0;
      wr.index   = tlen_ff[2:0];
      wr.data    = data_byte;
      result     = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_NONE, 8'h00, 1'b0, 4'd0};
      if (command == hrp_pkg::CMD_START) begin
         phase_in = hrp_pkg::PH_METHOD;
         tlen_in  = '0;
         total_in = '0;
      end else if (command == hrp_pkg::CMD_RESERVED || finished) begin
         result.status = hrp_pkg::ST_IGNORED;
      end else if (command == hrp_pkg::CMD_CLOSE) begin
         phase_in      = hrp_pkg::PH_CLOSED;
         result.status = hrp_pkg::ST_CLOSED;
      end else begin
         case (phase_ff)
            hrp_pkg::PH_METHOD: begin
               if (is_upper) begin
                  if (tlen_ff >= hrp_pkg::TOKEN_LEN_W'(hrp_pkg::MAX_METHOD_LEN)) begin
                     bad = 1'b1;
                  end else begin
                     wr.en   = short_room;
                     tlen_in = tlen_ff + 1'b1;
                     result  = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_METHOD, data_byte,
                                 1'b0, 4'd0};
                  end
               end else if (data_byte == hrp_pkg::CHAR_SP && method_ok) begin
                  phase_in = hrp_pkg::PH_URI;
                  tlen_in  = '0;
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_METHOD, data_byte,
                               1'b1, method_code};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_URI: begin
               if (is_print && data_byte != hrp_pkg::CHAR_SP) begin
                  if (tlen_ff >= limits.uri_max) begin
                     bad = 1'b1;
                  end else begin
                     tlen_in = tlen_ff + 1'b1;
                     result  = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_URI, data_byte,
                                 1'b0, 4'd0};
                  end
               end else if (data_byte == hrp_pkg::CHAR_SP && tlen_ff != '0) begin
                  phase_in = hrp_pkg::PH_VERSION;
                  tlen_in  = '0;
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_URI, data_byte,
                               1'b1, 4'd0};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_VERSION: begin
               if (is_print && data_byte != hrp_pkg::CHAR_SP) begin
                  if (tlen_ff >= hrp_pkg::TOKEN_LEN_W'(hrp_pkg::MAX_VERSION_LEN)) begin
                     bad = 1'b1;
                  end else begin
                     wr.en   = short_room;
                     tlen_in = tlen_ff + 1'b1;
                     result  = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_VERSION, data_byte,
                                 1'b0, 4'd0};
                  end
               end else if (data_byte == hrp_pkg::CHAR_CR && version_ok) begin
                  phase_in = hrp_pkg::PH_RL_LF;
                  tlen_in  = '0;
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_VERSION, data_byte,
                               1'b1, 4'd0};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_RL_LF: begin
               if (data_byte == hrp_pkg::CHAR_LF) begin
                  phase_in = hrp_pkg::PH_H_START;
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_H_START: begin
               if (is_key) begin
                  phase_in = hrp_pkg::PH_H_KEY;
                  tlen_in  = hrp_pkg::TOKEN_LEN_W'(1);
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_KEY, data_byte,
                               1'b0, 4'd0};
               end else if (data_byte == hrp_pkg::CHAR_CR) begin
                  phase_in = hrp_pkg::PH_BLANK_LF;
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_H_KEY: begin
               if (is_key) begin
                  if (tlen_ff >= {6'd0, limits.key_max}) begin
                     bad = 1'b1;
                  end else begin
                     tlen_in = tlen_ff + 1'b1;
                     result  = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_KEY, data_byte,
                                 1'b0, 4'd0};
                  end
               end else if (data_byte == hrp_pkg::CHAR_COLON) begin
                  total_in = total_sum;
                  tlen_in  = '0;
                  phase_in = hrp_pkg::PH_H_SPLIT1;
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_KEY, data_byte,
                               1'b1, 4'd0};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_H_SPLIT1, hrp_pkg::PH_H_SPLIT2: begin
               if (data_byte == hrp_pkg::CHAR_SP && phase_ff == hrp_pkg::PH_H_SPLIT1) begin
                  phase_in = hrp_pkg::PH_H_SPLIT2;
               end else if (is_print && data_byte != hrp_pkg::CHAR_SP) begin
                  phase_in = hrp_pkg::PH_H_VALUE;
                  tlen_in  = hrp_pkg::TOKEN_LEN_W'(1);
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_VALUE, data_byte,
                               1'b0, 4'd0};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_H_VALUE: begin
               if (is_print) begin
                  if (tlen_ff >= limits.value_max) begin
                     bad = 1'b1;
                  end else begin
                     tlen_in = tlen_ff + 1'b1;
                     result  = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_VALUE, data_byte,
                                 1'b0, 4'd0};
                  end
               end else if (data_byte == hrp_pkg::CHAR_CR) begin
                  phase_in = hrp_pkg::PH_H_LF;
                  result   = '{hrp_pkg::ST_PROGRESS, hrp_pkg::KIND_VALUE, data_byte,
                               1'b1, 4'd0};
               end else begin
                  bad = 1'b1;
               end
            end
            hrp_pkg::PH_H_LF: begin
               if (data_byte != hrp_pkg::CHAR_LF) begin
                  bad = 1'b1;
               end else begin
                  total_in = total_sum;
                  tlen_in  = '0;
                  if (total_sum > {1'b0, limits.total_max}) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = hrp_pkg::PH_H_START;
                  end
               end
            end
            hrp_pkg::PH_BLANK_LF: begin
               if (data_byte == hrp_pkg::CHAR_LF) begin
                  phase_in      = hrp_pkg::PH_DONE;
                  result.status = hrp_pkg::ST_COMPLETE;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase
         if (bad) begin
            phase_in = hrp_pkg::PH_BAD;
            wr.en    = 1'b0;
            result   = '{hrp_pkg::ST_BAD, hrp_pkg::KIND_NONE, 8'h00, 1'b0, 4'd0};
         end
      end
      wr.en = wr.en && take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrp_pkg::PH_METHOD;
         tlen_ff  <= '0;
         total_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         tlen_ff  <= tlen_in;
         total_ff <= total_in;
      end
   end

endmodule

/* rtl/http_request_head_parser_unit.sv */
// Output: a result is registered and appears on rsp in the cycle after its item is accepted on req.
// Throughput: one item per cycle while rsp_tready is high; the phase update and the
// fixed-string compares against the short token store set this.
// Reset (synchronous, active high): phase returns to the method, lengths and the
// header total clear, limit registers return to their defaults, rsp goes empty.
// ============================================================================
// HTTP request head parser, top level
// Configuration registers, parse core, short token store and result register.
// ============================================================================
module http_request_head_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] status, [10:3] token_byte, [14:11] method_code
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast,   // token_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   hrp_pkg::limits_type      limits_ff, limits_in;
   hrp_pkg::match_type       match;
   hrp_pkg::store_write_type wr;
   hrp_pkg::result_type      result;
   hrp_pkg::result_type      rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     take;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         case (csr_index)
            hrp_pkg::CSR_URI_MAX:   limits_in.uri_max   = csr_data[13:0];
            hrp_pkg::CSR_KEY_MAX:   limits_in.key_max   = csr_data[7:0];
            hrp_pkg::CSR_VALUE_MAX: limits_in.value_max = csr_data[13:0];
            hrp_pkg::CSR_TOTAL_MAX: limits_in.total_max = csr_data;
            default:                limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{14'd2048, 8'd64, 14'd1024, 16'd8192};
      end else begin
         limits_ff <= limits_in;
      end
   end

   hrp_char_store u_store (
      .clock (clock),
      .wr    (wr),
      .match (match)
   );

   hrp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .command   (req_tuser),
      .data_byte (req_tdata),
      .limits    (limits_ff),
      .match     (match),
      .wr        (wr),
      .result    (result)
   );

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.method_code, rsp_ff.token_byte, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.token_kind;
   assign rsp_tlast  = rsp_ff.token_end;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      take && req_tuser == hrp_pkg::CMD_START |=>
         rsp_ff.status == hrp_pkg::ST_PROGRESS && rsp_ff.token_kind == hrp_pkg::KIND_NONE)
      else $error("start command gave wrong result");

   a_reserved_ignored: assert property (@(posedge clock) disable iff (reset)
      take && req_tuser == hrp_pkg::CMD_RESERVED |=> rsp_ff.status == hrp_pkg::ST_IGNORED)
      else $error("reserved command not ignored");

   a_code_at_method_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.method_code != 4'd0 |->
         rsp_ff.token_end && rsp_ff.token_kind == hrp_pkg::KIND_METHOD)
      else $error("method code outside method end");

endmodule
